### rtl/core/hbrq_pkg.sv
package hbrq_pkg;

   localparam int unsigned QUEUE_DEPTH_DEF = 64;

   localparam int unsigned SEQ_W      = 64;
   localparam int unsigned CHUNK_W    = 32;
   localparam int unsigned REF_W      = 16;
   localparam int unsigned THR_W      = 7;
   localparam int unsigned CSR_ADDR_W = 1;

   localparam logic [CSR_ADDR_W-1:0] CSR_UPPER = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOWER = 1'd1;

   localparam logic [THR_W-1:0] UPPER_RESET = 7'd48;
   localparam logic [THR_W-1:0] LOWER_RESET = 7'd16;

   localparam int unsigned REQ_DATA_W = 112;
   localparam int unsigned RSP_DATA_W = 128;

   // seq in the lowest bits
   typedef struct packed {
      logic [REF_W-1:0]   buf_ref;
      logic [CHUNK_W-1:0] chunk;
      logic [SEQ_W-1:0]   seq;
   } tag_type;

   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctl_type;

   // emit tag in the lowest bits
   typedef struct packed {
      logic             overflow;
      logic             queue_empty;
      logic [THR_W-1:0] queue_count;
      logic             pressure_active;
      logic             release_pressure;
      logic             apply_pressure;
      tag_type          emit;
   } rsp_type;

   localparam int unsigned RSP_PAD_W = RSP_DATA_W - $bits(rsp_type);

endpackage

### rtl/core/hbrq_fifo.sv
module hbrq_fifo #(
   parameter int unsigned DEPTH = hbrq_pkg::QUEUE_DEPTH_DEF,
   localparam int unsigned PTR_W = $clog2(DEPTH),
   localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  hbrq_pkg::fifo_ctl_type ctl,
   input  hbrq_pkg::tag_type      wr_tag,
   output hbrq_pkg::tag_type      head_tag,
   output logic [CNT_W-1:0]       count
);

   hbrq_pkg::tag_type mem [DEPTH];
   hbrq_pkg::tag_type head_ff;

   logic [PTR_W-1:0] head_ptr_ff, head_ptr_in;
   logic [PTR_W-1:0] tail_ptr_ff, tail_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [PTR_W-1:0] rd_addr;
   logic             bypass;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      head_ptr_in = ctl.pop  ? next_ptr(head_ptr_ff) : head_ptr_ff;
      tail_ptr_in = ctl.push ? next_ptr(tail_ptr_ff) : tail_ptr_ff;
      cnt_in      = cnt_ff + CNT_W'(ctl.push) - CNT_W'(ctl.pop);
      rd_addr     = head_ptr_in;
      // new head is the tag written in this transfer
      bypass      = ctl.push && ((cnt_ff == '0) || (ctl.pop && (cnt_ff == CNT_W'(1))));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ptr_ff <= '0;
         tail_ptr_ff <= '0;
         cnt_ff      <= '0;
      end else begin
         head_ptr_ff <= head_ptr_in;
         tail_ptr_ff <= tail_ptr_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[tail_ptr_ff] <= wr_tag;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= bypass ? wr_tag : mem[rd_addr];
   end

   assign head_tag = head_ff;
   assign count    = cnt_ff;

endmodule

### rtl/core/hysteresis_backpressure_retry_queue.sv
// Result: each request transfer registers its result, which is shown in the following cycle.
// Throughput: one request per cycle; a waiting result does not stall input
// while the consumer takes it in the same cycle.
// Reset: synchronous; clears queue pointers, count, retry slot and pressure,
// loads thresholds 48 and 16. Queue storage is not cleared and needs no pass.
module hysteresis_backpressure_retry_queue #(
   parameter int unsigned QUEUE_DEPTH = hbrq_pkg::QUEUE_DEPTH_DEF,
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hbrq_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [hbrq_pkg::THR_W-1:0]          csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // seq_number[63:0], chunk_num[95:64], buffer_ref[111:96]
   input  logic [hbrq_pkg::REQ_DATA_W-1:0]     req_tdata,
   // mode
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // emit_seq[63:0], emit_chunk[95:64], emit_ref[111:96], apply_pressure[112],
   // release_pressure[113], pressure_active[114], queue_count[121:115],
   // queue_empty[122], overflow[123], zero[127:124]
   output logic [hbrq_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // emit_valid
   output logic                                rsp_tuser
);

   localparam int unsigned THR_W = hbrq_pkg::THR_W;
   localparam int unsigned CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;

   logic [THR_W-1:0] upper_ff, lower_ff;
   logic             retry_valid_ff, retry_valid_in;
   logic [hbrq_pkg::SEQ_W-1:0]   retry_seq_ff, retry_seq_in;
   logic [hbrq_pkg::CHUNK_W-1:0] retry_chunk_ff, retry_chunk_in;
   logic             pressure_ff, pressure_in;
   logic             rsp_valid_ff;
   logic             emit_valid_ff, emit_valid_in;
   hbrq_pkg::rsp_type rsp_ff, rsp_in;

   hbrq_pkg::fifo_ctl_type fifo_ctl;
   hbrq_pkg::tag_type      req_tag;
   hbrq_pkg::tag_type      head_tag;
   logic [CNT_W-1:0]       cnt;
   logic [CNT_W-1:0]       cnt_push;
   logic [CNT_W-1:0]       cnt_after;
   logic [THR_W-1:0]       thr_hi, thr_lo;
   logic                   req_fire;
   logic                   match;

   hbrq_fifo #(
      .DEPTH(QUEUE_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .ctl     (fifo_ctl),
      .wr_tag  (req_tag),
      .head_tag(head_tag),
      .count   (cnt)
   );

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign req_tag    = hbrq_pkg::tag_type'(req_tdata);

   assign thr_hi = (upper_ff > lower_ff) ? upper_ff : lower_ff;
   assign thr_lo = (upper_ff > lower_ff) ? lower_ff : upper_ff;

   assign match = retry_valid_ff && (req_tag.seq == retry_seq_ff)
                  && (req_tag.chunk == retry_chunk_ff);

   always_comb begin
      fifo_ctl       = '0;
      retry_valid_in = retry_valid_ff;
      retry_seq_in   = retry_seq_ff;
      retry_chunk_in = retry_chunk_ff;
      pressure_in    = pressure_ff;
      emit_valid_in  = 1'b0;
      rsp_in         = '0;
      cnt_push       = cnt;
      if (!req_tuser) begin
         if (match) begin
            emit_valid_in = 1'b1;
            rsp_in.emit   = req_tag;
         end else begin
            if (cnt == CNT_W'(QUEUE_DEPTH)) begin
               rsp_in.overflow = 1'b1;
            end else begin
               fifo_ctl.push = 1'b1;
               cnt_push      = cnt + 1'b1;
            end
            if (!pressure_ff && (CMP_W'(cnt_push) >= CMP_W'(thr_hi))) begin
               pressure_in           = 1'b1;
               rsp_in.apply_pressure = 1'b1;
            end
            if (!retry_valid_ff && (cnt_push != '0)) begin
               fifo_ctl.pop   = 1'b1;
               emit_valid_in  = 1'b1;
               rsp_in.emit    = (cnt == '0) ? req_tag : head_tag;
               retry_valid_in = 1'b1;
               retry_seq_in   = rsp_in.emit.seq;
               retry_chunk_in = rsp_in.emit.chunk;
            end
         end
      end else begin
         retry_valid_in = 1'b0;
         retry_seq_in   = '0;
         retry_chunk_in = '0;
         if (pressure_ff && (CMP_W'(cnt) <= CMP_W'(thr_lo))) begin
            pressure_in             = 1'b0;
            rsp_in.release_pressure = 1'b1;
         end
         if (cnt != '0) begin
            fifo_ctl.pop  = 1'b1;
            emit_valid_in = 1'b1;
            rsp_in.emit   = head_tag;
         end
      end
      cnt_after              = cnt_push - CNT_W'(fifo_ctl.pop);
      rsp_in.pressure_active = pressure_in;
      rsp_in.queue_count     = THR_W'(cnt_after);
      rsp_in.queue_empty     = (cnt_after == '0);
      if (!req_fire) begin
         fifo_ctl = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= hbrq_pkg::UPPER_RESET;
         lower_ff <= hbrq_pkg::LOWER_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_addr)
            hbrq_pkg::CSR_UPPER: upper_ff <= csr_wdata;
            hbrq_pkg::CSR_LOWER: lower_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_valid_ff <= 1'b0;
         retry_seq_ff   <= '0;
         retry_chunk_ff <= '0;
         pressure_ff    <= 1'b0;
      end else if (req_fire) begin
         retry_valid_ff <= retry_valid_in;
         retry_seq_ff   <= retry_seq_in;
         retry_chunk_ff <= retry_chunk_in;
         pressure_ff    <= pressure_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff        <= rsp_in;
         emit_valid_ff <= emit_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{hbrq_pkg::RSP_PAD_W{1'b0}}, rsp_ff};
   assign rsp_tuser  = emit_valid_ff;

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("no result after request transfer");

   a_pressure_level: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (rsp_ff.pressure_active == pressure_ff))
      else $error("reported pressure level differs from flag");

   a_count_level: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (rsp_ff.queue_count == THR_W'(cnt)))
      else $error("reported count differs from queue");

   a_ok_clears_retry: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser |=> !retry_valid_ff)
      else $error("retry slot kept after send ok");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      req_fire && (cnt == CNT_W'(QUEUE_DEPTH)) && !req_tuser && !match
      |=> rsp_ff.overflow && (cnt != '0))
      else $error("full queue transfer not flagged");

endmodule

### verif/tb_hysteresis_backpressure_retry_queue.sv
`timescale 1ns / 1ps

module tb_hysteresis_backpressure_retry_queue;
   import hbrq_pkg::*;

   localparam int unsigned DEPTH = QUEUE_DEPTH_DEF;
   localparam int unsigned NUM_PHASES = 8;

   typedef struct packed {
      logic    emit_valid;
      rsp_type rsp;
   } emit_result_type;

   class retry_queue_shadow;
      tag_type         shadow_tags[$];
      emit_result_type pending_emits[$];
      logic            slot_valid;
      logic [SEQ_W-1:0]   slot_seq;
      logic [CHUNK_W-1:0] slot_chunk;
      logic            pressure;
      logic [THR_W-1:0] upper_thr;
      logic [THR_W-1:0] lower_thr;
      int errors;
      int events_seen;
      int emits_checked;
      int retry_hits;
      int drops;
      int raises;
      int releases;

      function new();
         slot_valid = 1'b0;
         slot_seq = '0;
         slot_chunk = '0;
         pressure = 1'b0;
         upper_thr = UPPER_RESET;
         lower_thr = LOWER_RESET;
         errors = 0;
         events_seen = 0;
         emits_checked = 0;
         retry_hits = 0;
         drops = 0;
         raises = 0;
         releases = 0;
      endfunction

      function void set_threshold(logic [CSR_ADDR_W-1:0] addr, logic [THR_W-1:0] value);
         if (addr == CSR_UPPER) begin
            upper_thr = value;
         end else if (addr == CSR_LOWER) begin
            lower_thr = value;
         end
      endfunction

      function void record_event(logic send_ok, tag_type t);
         int hi;
         int lo;
         emit_result_type r;
         hi = int'((upper_thr > lower_thr) ? upper_thr : lower_thr);
         lo = int'((upper_thr > lower_thr) ? lower_thr : upper_thr);
         r = '0;
         events_seen++;
         if (!send_ok) begin
            if (slot_valid && t.seq == slot_seq && t.chunk == slot_chunk) begin
               r.emit_valid = 1'b1;
               r.rsp.emit = t;
               retry_hits++;
            end else begin
               if (shadow_tags.size() >= DEPTH) begin
                  r.rsp.overflow = 1'b1;
                  drops++;
               end else begin
                  shadow_tags.push_back(t);
               end
               if (!pressure && shadow_tags.size() >= hi) begin
                  pressure = 1'b1;
                  r.rsp.apply_pressure = 1'b1;
                  raises++;
               end
               if (!slot_valid && shadow_tags.size() > 0) begin
                  r.rsp.emit = shadow_tags[0];
                  shadow_tags.delete(0);
                  r.emit_valid = 1'b1;
                  slot_valid = 1'b1;
                  slot_seq = r.rsp.emit.seq;
                  slot_chunk = r.rsp.emit.chunk;
               end
            end
         end else begin
            slot_valid = 1'b0;
            slot_seq = '0;
            slot_chunk = '0;
            if (pressure && shadow_tags.size() <= lo) begin
               pressure = 1'b0;
               r.rsp.release_pressure = 1'b1;
               releases++;
            end
            if (shadow_tags.size() > 0) begin
               r.rsp.emit = shadow_tags[0];
               shadow_tags.delete(0);
               r.emit_valid = 1'b1;
            end
         end
         r.rsp.pressure_active = pressure;
         r.rsp.queue_count = THR_W'(shadow_tags.size());
         r.rsp.queue_empty = (shadow_tags.size() == 0);
         pending_emits.push_back(r);
      endfunction

      function void check_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_emit(logic tuser, logic [RSP_DATA_W-1:0] data);
         emit_result_type want;
         rsp_type got;
         got = data[$bits(rsp_type)-1:0];
         if (pending_emits.size() == 0) begin
            $error("result transfer with nothing outstanding: 0x%0h", data);
            errors++;
            return;
         end
         want = pending_emits[0];
         pending_emits.delete(0);
         emits_checked++;
         check_field("emit_valid", 64'(want.emit_valid), 64'(tuser));
         check_field("emit_seq", want.rsp.emit.seq, got.emit.seq);
         check_field("emit_chunk", 64'(want.rsp.emit.chunk), 64'(got.emit.chunk));
         check_field("emit_ref", 64'(want.rsp.emit.buf_ref), 64'(got.emit.buf_ref));
         check_field("apply_pressure", 64'(want.rsp.apply_pressure),
                     64'(got.apply_pressure));
         check_field("release_pressure", 64'(want.rsp.release_pressure),
                     64'(got.release_pressure));
         check_field("pressure_active", 64'(want.rsp.pressure_active),
                     64'(got.pressure_active));
         check_field("queue_count", 64'(want.rsp.queue_count), 64'(got.queue_count));
         check_field("queue_empty", 64'(want.rsp.queue_empty), 64'(got.queue_empty));
         check_field("overflow", 64'(want.rsp.overflow), 64'(got.overflow));
         check_field("pad", 64'(0), 64'(data[RSP_DATA_W-1 -: RSP_PAD_W]));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [THR_W-1:0] csr_wdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tuser;

   logic steady_ready = 1'b0;
   int stall_left = 0;
   int burst_left = 0;
   retry_queue_shadow sb;

   int unsigned phase_upper[NUM_PHASES] = '{64, 10, 0, 64, 30, 20, 0, 48};
   int unsigned phase_lower[NUM_PHASES] = '{0, 40, 0, 64, 5, 20, 0, 16};
   int unsigned phase_ok_pct[NUM_PHASES] = '{5, 85, 40, 10, 80, 45, 50, 30};
   int unsigned phase_items[NUM_PHASES] = '{90, 70, 60, 80, 70, 70, 60, 60};

   hysteresis_backpressure_retry_queue dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_left <= $urandom_range(1, 12);
         rsp_tready <= steady_ready || ($urandom_range(0, 2) != 0);
      end else begin
         stall_left <= stall_left - 1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_emit(rsp_tuser, rsp_tdata);
      end
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   task automatic send_event(logic send_ok, tag_type t);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= send_ok;
      req_tdata <= t;
      do @(posedge clock); while (!req_tready);
      sb.record_event(send_ok, t);
   endtask

   task automatic drain_emits();
      req_tvalid <= 1'b0;
      while (sb.pending_emits.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_ADDR_W-1:0] addr, logic [THR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_threshold(addr, value);
   endtask

   task automatic set_thresholds(logic [THR_W-1:0] upper, logic [THR_W-1:0] lower);
      write_csr(CSR_UPPER, upper);
      write_csr(CSR_LOWER, lower);
      csr_valid <= 1'b0;
   endtask

   function automatic tag_type pick_tag();
      tag_type t;
      int k;
      t.seq = {$urandom, $urandom};
      t.chunk = $urandom;
      t.buf_ref = 16'($urandom_range(0, 65535));
      k = $urandom_range(0, 99);
      if (k < 25 && sb.slot_valid) begin
         t.seq = sb.slot_seq;
         t.chunk = sb.slot_chunk;
      end else if (k < 32 && sb.slot_valid) begin
         t.seq = sb.slot_seq;
      end else if (k < 38 && sb.slot_valid) begin
         t.chunk = sb.slot_chunk;
      end else if (k < 44) begin
         t.seq = '1;
         t.chunk = '0;
      end else if (k < 48) begin
         t = '0;
      end else if (k < 52) begin
         t = '1;
      end
      return t;
   endfunction

   initial begin
      tag_type ones;
      tag_type t;
      int p;
      int i;
      sb = new();
      ones = '1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // send ok on empty queue, first retry, retry hit, near misses, pops to empty
      send_event(1'b1, '0);
      send_event(1'b0, ones);
      t = ones;
      t.buf_ref = 16'h1234;
      send_event(1'b0, t);
      t = '0;
      t.seq = '1;
      send_event(1'b0, t);
      send_event(1'b0, '0);
      t = '0;
      t.chunk = '1;
      t.buf_ref = '1;
      send_event(1'b0, t);
      send_event(1'b1, ones);
      send_event(1'b0, ones);
      send_event(1'b1, '0);
      send_event(1'b1, '0);
      send_event(1'b1, '0);
      send_event(1'b1, '0);

      for (p = 0; p < NUM_PHASES; p++) begin
         drain_emits();
         if (p == 6) begin
            phase_upper[p] = $urandom_range(0, 64);
            phase_lower[p] = $urandom_range(0, 64);
         end
         set_thresholds(THR_W'(phase_upper[p]), THR_W'(phase_lower[p]));
         steady_ready <= (p % 3 == 2);
         for (i = 0; i < phase_items[p]; i++) begin
            send_event($urandom_range(0, 99) < phase_ok_pct[p], pick_tag());
         end
      end
      drain_emits();
      repeat (10) @(posedge clock);

      if (sb.pending_emits.size() != 0) begin
         $error("%0d results never arrived", sb.pending_emits.size());
         sb.errors++;
      end
      $display("Run: %0d events in, %0d results checked over %0d threshold settings",
               sb.events_seen, sb.emits_checked, NUM_PHASES + 1);
      $display("Run: %0d retry hits, %0d drops on full queue, pressure raised %0d, released %0d",
               sb.retry_hits, sb.drops, sb.raises, sb.releases);
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/hbrq_pkg.sv
rtl/core/hbrq_fifo.sv
rtl/core/hysteresis_backpressure_retry_queue.sv
verif/tb_hysteresis_backpressure_retry_queue.sv
